FILE: rtl/fspc_pkg.sv
// ----------------------------------------------------------------------------
// fspc_pkg
// Shared constants, types and plane tables for the frustum side-plane cull.
// ----------------------------------------------------------------------------
package fspc_pkg;

  // Configuration port
  localparam int CFG_W     = 63;
  localparam int CFG_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CAMERA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TR     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BL     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BR     = 3'd4;

  // Default coordinate width
  localparam int COORD_WIDTH_DEF = 21;

  // Unit normal format: Q.30 magnitude, signed 32-bit word
  localparam int UNIT_BITS = 30;
  localparam int UNIT_W    = UNIT_BITS + 2;
  localparam int LEN_W     = UNIT_BITS + 1;
  localparam int SQ_W      = 2 * UNIT_BITS;
  localparam int SUMSQ_W   = SQ_W + 2;

  localparam int NUM_PLANES  = 4;
  localparam int NUM_CORNERS = 4;

  typedef logic signed [UNIT_W-1:0] unit_t;
  typedef unit_t [2:0] unit_vec_t;
  typedef unit_vec_t [NUM_PLANES-1:0] plane_set_t;

  typedef logic [NUM_CORNERS-1:0][CFG_W-1:0] corner_set_t;

  // Setup status toward the item pipeline
  typedef struct packed {
    logic busy;
  } setup_status_t;

  // Corner order in corner_set_t: top-left, top-right, bottom-left, bottom-right
  localparam logic [1:0] CORNER_TL = 2'd0;
  localparam logic [1:0] CORNER_TR = 2'd1;
  localparam logic [1:0] CORNER_BL = 2'd2;
  localparam logic [1:0] CORNER_BR = 2'd3;

  // Planes: left, right, top, bottom
  localparam logic [1:0] PLANE_LEFT   = 2'd0;
  localparam logic [1:0] PLANE_RIGHT  = 2'd1;
  localparam logic [1:0] PLANE_TOP    = 2'd2;
  localparam logic [1:0] PLANE_BOTTOM = 2'd3;

  // First corner of the cross product for a plane
  function automatic logic [1:0] plane_corner_a(input logic [1:0] plane);
    logic [1:0] c;
    case (plane)
      PLANE_LEFT:   c = CORNER_TL;
      PLANE_RIGHT:  c = CORNER_BR;
      PLANE_TOP:    c = CORNER_TR;
      PLANE_BOTTOM: c = CORNER_BL;
      default:      c = CORNER_TL;
    endcase
    return c;
  endfunction

  // Second corner of the cross product for a plane
  function automatic logic [1:0] plane_corner_b(input logic [1:0] plane);
    logic [1:0] c;
    case (plane)
      PLANE_LEFT:   c = CORNER_BL;
      PLANE_RIGHT:  c = CORNER_TR;
      PLANE_TOP:    c = CORNER_TL;
      PLANE_BOTTOM: c = CORNER_BR;
      default:      c = CORNER_TL;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/fspc_obj_if.sv
// ----------------------------------------------------------------------------
// fspc_obj_if
// Object channel: centre and margin sizes per beat.
// ----------------------------------------------------------------------------
interface fspc_obj_if #(
  parameter int CoordWidth = fspc_pkg::COORD_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] obj_x;
  logic signed [CoordWidth-1:0] obj_y;
  logic signed [CoordWidth-1:0] obj_z;
  logic        [CoordWidth-2:0] size_x;
  logic        [CoordWidth-2:0] size_y;

  modport source (output valid, obj_x, obj_y, obj_z, size_x, size_y, input ready);
  modport sink   (input valid, obj_x, obj_y, obj_z, size_x, size_y, output ready);
endinterface

FILE: rtl/fspc_res_if.sv
// ----------------------------------------------------------------------------
// fspc_res_if
// Result channel: one visibility bit per beat.
// ----------------------------------------------------------------------------
interface fspc_res_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

FILE: rtl/fspc_setup.sv
// ----------------------------------------------------------------------------
// fspc_setup
// Sequencer that derives the four Q.30 unit plane normals from the camera and
// far corners: cross product, range shift, integer square root, division.
// ----------------------------------------------------------------------------
module fspc_setup #(
  parameter int CoordWidth = fspc_pkg::COORD_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [fspc_pkg::CFG_W-1:0] cam_i,
  input  fspc_pkg::corner_set_t corners_i,
  output fspc_pkg::setup_status_t status_o,
  output fspc_pkg::plane_set_t  unit_o
);
  import fspc_pkg::*;

  localparam int DW   = CoordWidth + 1;
  localparam int PW   = 2 * DW;
  localparam int NW   = PW + 1;
  localparam int MAGW = (PW > UNIT_BITS + 1) ? PW : UNIT_BITS + 1;
  localparam int DIV_STEPS = 2 * UNIT_BITS;
  localparam int DCNT_W = $clog2(DIV_STEPS);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DIFF  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_CROSS = 4'd3;
  localparam logic [3:0] ST_SHIFT = 4'd4;
  localparam logic [3:0] ST_SQ    = 4'd5;
  localparam logic [3:0] ST_SUM   = 4'd6;
  localparam logic [3:0] ST_SQRT  = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_STORE = 4'd9;

  logic [3:0] state_q;
  logic [1:0] plane_q;

  logic signed [DW-1:0] a_q [3];
  logic signed [DW-1:0] b_q [3];
  logic signed [PW-1:0] pr_q [6];
  logic                 neg_q [3];
  logic [MAGW-1:0]      mag_q [3];
  logic [SQ_W-1:0]      sq_q [3];
  logic [SUMSQ_W-1:0]   rem_q;
  logic [SUMSQ_W-1:0]   res_q;
  logic [SQ_W:0]        bit_q;
  logic [LEN_W-1:0]     len_q;
  logic [LEN_W-1:0]     drem_q [3];
  logic [LEN_W-1:0]     quo_q [3];
  logic [UNIT_BITS-1:0] dvd_q [3];
  logic [DCNT_W-1:0]    dcnt_q;
  plane_set_t           unit_q;

  logic [CFG_W-1:0] corner_a, corner_b;
  logic signed [NW-1:0] n_cross [3];
  logic                 over_range;
  logic [SUMSQ_W-1:0]   sqrt_trial;
  logic [LEN_W:0]       div_trial [3];

  // Pick the corner pair of the current plane
  assign corner_a = corners_i[plane_corner_a(plane_q)];
  assign corner_b = corners_i[plane_corner_b(plane_q)];

  // Cross product components from the registered products
  assign n_cross[0] = NW'(pr_q[0]) - NW'(pr_q[1]);
  assign n_cross[1] = NW'(pr_q[2]) - NW'(pr_q[3]);
  assign n_cross[2] = NW'(pr_q[4]) - NW'(pr_q[5]);

  assign over_range = (|mag_q[0][MAGW-1:UNIT_BITS]) | (|mag_q[1][MAGW-1:UNIT_BITS]) |
                      (|mag_q[2][MAGW-1:UNIT_BITS]);

  assign sqrt_trial = res_q + SUMSQ_W'(bit_q);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      div_trial[i] = {drem_q[i], dvd_q[i][UNIT_BITS-1]};
    end
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      plane_q <= '0;
      dcnt_q  <= '0;
      unit_q  <= '0;
    end else if (start_i) begin
      state_q <= ST_DIFF;
      plane_q <= '0;
    end else begin
      case (state_q)
        ST_IDLE:  state_q <= ST_IDLE;
        ST_DIFF:  state_q <= ST_MUL;
        ST_MUL:   state_q <= ST_CROSS;
        ST_CROSS: state_q <= ST_SHIFT;
        ST_SHIFT: begin
          if (!over_range) state_q <= ST_SQ;
        end
        ST_SQ:    state_q <= ST_SUM;
        ST_SUM:   state_q <= ST_SQRT;
        ST_SQRT: begin
          if (bit_q == (SQ_W+1)'(1)) begin
            dcnt_q  <= '0;
            // zero-length normal: skip the divide, the unit is stored as zero
            state_q <= (sqrt_trial <= rem_q || res_q != '0) ? ST_DIV : ST_STORE;
          end
        end
        ST_DIV: begin
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) state_q <= ST_STORE;
        end
        ST_STORE: begin
          for (int i = 0; i < 3; i++) begin
            unit_q[plane_q][i] <= neg_q[i] ? -UNIT_W'(quo_q[i]) : UNIT_W'(quo_q[i]);
          end
          plane_q <= plane_q + 1'b1;
          state_q <= (plane_q == PLANE_BOTTOM) ? ST_IDLE : ST_DIFF;
        end
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          a_q[i] <= DW'($signed(corner_a[i*CoordWidth +: CoordWidth]))
                  - DW'($signed(cam_i[i*CoordWidth +: CoordWidth]));
          b_q[i] <= DW'($signed(corner_b[i*CoordWidth +: CoordWidth]))
                  - DW'($signed(cam_i[i*CoordWidth +: CoordWidth]));
        end
      end
      ST_MUL: begin
        pr_q[0] <= a_q[1] * b_q[2];
        pr_q[1] <= a_q[2] * b_q[1];
        pr_q[2] <= a_q[2] * b_q[0];
        pr_q[3] <= a_q[0] * b_q[2];
        pr_q[4] <= a_q[0] * b_q[1];
        pr_q[5] <= a_q[1] * b_q[0];
      end
      ST_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          neg_q[i] <= n_cross[i][NW-1];
          mag_q[i] <= n_cross[i][NW-1] ? MAGW'(-n_cross[i]) : MAGW'(n_cross[i]);
        end
      end
      ST_SHIFT: begin
        // drop one bit at a time until the largest magnitude fits
        if (over_range) begin
          for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
        end
      end
      ST_SQ: begin
        for (int i = 0; i < 3; i++) begin
          sq_q[i] <= mag_q[i][UNIT_BITS-1:0] * mag_q[i][UNIT_BITS-1:0];
        end
      end
      ST_SUM: begin
        rem_q <= SUMSQ_W'(sq_q[0]) + SUMSQ_W'(sq_q[1]) + SUMSQ_W'(sq_q[2]);
        res_q <= '0;
        bit_q <= (SQ_W+1)'(1) << SQ_W;
      end
      ST_SQRT: begin
        // one result bit per cycle
        if (rem_q >= sqrt_trial) begin
          rem_q <= rem_q - sqrt_trial;
          res_q <= (res_q >> 1) + SUMSQ_W'(bit_q);
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
        if (bit_q == (SQ_W+1)'(1)) begin
          len_q <= (rem_q >= sqrt_trial) ? LEN_W'((res_q >> 1) + SUMSQ_W'(bit_q))
                                         : LEN_W'(res_q >> 1);
          for (int i = 0; i < 3; i++) begin
            drem_q[i] <= '0;
            quo_q[i]  <= '0;
            dvd_q[i]  <= mag_q[i][UNIT_BITS-1:0];
          end
        end
      end
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle on each component
        for (int i = 0; i < 3; i++) begin
          if (div_trial[i] >= {1'b0, len_q}) begin
            drem_q[i] <= LEN_W'(div_trial[i] - {1'b0, len_q});
            quo_q[i]  <= {quo_q[i][LEN_W-2:0], 1'b1};
          end else begin
            drem_q[i] <= LEN_W'(div_trial[i]);
            quo_q[i]  <= {quo_q[i][LEN_W-2:0], 1'b0};
          end
          dvd_q[i] <= {dvd_q[i][UNIT_BITS-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  assign status_o.busy = (state_q != ST_IDLE);
  assign unit_o        = unit_q;

`ifndef SYNTH
  a_units_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !start_i) |=> $stable(unit_q))
    else $error("unit normals changed while setup idle");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> (state_q == ST_DIFF && plane_q == PLANE_LEFT))
    else $error("setup did not restart at the left plane");
  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (len_q != '0))
    else $error("divide entered with zero length");
`endif

endmodule

FILE: rtl/fspc_pipe.sv
// ----------------------------------------------------------------------------
// fspc_pipe
// Four-stage item pipeline: offset, twelve products, plane dots, margin test.
// ----------------------------------------------------------------------------
module fspc_pipe #(
  parameter int CoordWidth = fspc_pkg::COORD_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fspc_pkg::setup_status_t    status_i,
  input  logic [fspc_pkg::CFG_W-1:0] cam_i,
  input  fspc_pkg::plane_set_t       unit_i,
  input  logic                       hold_i,
  fspc_obj_if.sink                   obj_i,
  fspc_res_if.source                 res_o
);
  import fspc_pkg::*;

  localparam int DW   = CoordWidth + 1;
  localparam int SW   = CoordWidth - 1;
  localparam int PRW  = UNIT_W + DW;
  localparam int CMPW = PRW + 2;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  logic signed [DW-1:0]   off_q [3];
  logic [SW-1:0]          sx1_q, sy1_q, sx2_q, sy2_q, sx3_q, sy3_q;
  logic signed [PRW-1:0]  prod_q [NUM_PLANES][3];
  logic signed [CMPW-1:0] dot_q [NUM_PLANES];
  logic                   vis_q;

  logic signed [CMPW-1:0] thr [NUM_PLANES];
  logic [NUM_PLANES-1:0]  pass;

  // Advance a stage when it is empty or the next one moves
  assign en4 = !v4_q || res_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign obj_i.ready = en1 && !hold_i && !status_i.busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= obj_i.valid && obj_i.ready;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage 1: offset from camera
  always_ff @(posedge clk_i) begin
    if (en1) begin
      off_q[0] <= DW'(obj_i.obj_x) - DW'($signed(cam_i[0 +: CoordWidth]));
      off_q[1] <= DW'(obj_i.obj_y) - DW'($signed(cam_i[CoordWidth +: CoordWidth]));
      off_q[2] <= DW'(obj_i.obj_z) - DW'($signed(cam_i[2*CoordWidth +: CoordWidth]));
      sx1_q    <= obj_i.size_x;
      sy1_q    <= obj_i.size_y;
    end
  end

  // Stage 2: unit normal times offset
  always_ff @(posedge clk_i) begin
    if (en2) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int i = 0; i < 3; i++) begin
          prod_q[p][i] <= PRW'($signed(unit_i[p][i])) * PRW'(off_q[i]);
        end
      end
      sx2_q <= sx1_q;
      sy2_q <= sy1_q;
    end
  end

  // Stage 3: plane dots
  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        dot_q[p] <= CMPW'(prod_q[p][0]) + CMPW'(prod_q[p][1]) + CMPW'(prod_q[p][2]);
      end
      sx3_q <= sx2_q;
      sy3_q <= sy2_q;
    end
  end

  // Margin thresholds: twice size_x sideways, size_y on top, twice size_y below
  always_comb begin
    thr[PLANE_LEFT]   = -$signed(CMPW'({sx3_q, 1'b0}) << UNIT_BITS);
    thr[PLANE_RIGHT]  = -$signed(CMPW'({sx3_q, 1'b0}) << UNIT_BITS);
    thr[PLANE_TOP]    = -$signed(CMPW'(sy3_q) << UNIT_BITS);
    thr[PLANE_BOTTOM] = -$signed(CMPW'({sy3_q, 1'b0}) << UNIT_BITS);
    for (int p = 0; p < NUM_PLANES; p++) begin
      pass[p] = !(dot_q[p] < thr[p]);
    end
  end

  // Stage 4: output register
  always_ff @(posedge clk_i) begin
    if (en4) vis_q <= &pass;
  end

  assign res_o.valid   = v4_q;
  assign res_o.visible = vis_q;

`ifndef SYNTH
  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !en3) |=> v3_q)
    else $error("stalled stage lost its item");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.busy |-> !obj_i.ready)
    else $error("item accepted during setup");
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> (res_o.valid && $stable(res_o.visible)))
    else $error("result beat changed while stalled");
`endif

endmodule

FILE: rtl/frustum_side_plane_cull_core.sv
// ----------------------------------------------------------------------------
// frustum_side_plane_cull_core
// Tests objects against the four side planes of a view frustum.
// ----------------------------------------------------------------------------
// An accepted object beat passes the offset, product, dot and output registers.
// Throughput: one object per cycle while results are taken and no setup or
// configuration write holds input, set by the four-stage item pipeline. Each
// configuration write starts the normal setup sequencer, which holds off input
// for each of the four planes (shift search of up to 14 steps, 31-step square root, 60-step divide).
// Reset clears the registers and unit normals to zero; no setup pass needed.
module frustum_side_plane_cull_core #(
  parameter int CoordWidth = fspc_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [fspc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fspc_pkg::CFG_W-1:0]     cfg_data_i,
  fspc_obj_if.sink                       obj_i,
  fspc_res_if.source                     res_o
);
  import fspc_pkg::*;

  logic [CFG_W-1:0] cam_q;
  corner_set_t      corners_q;
  setup_status_t    status;
  plane_set_t       units;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_q     <= '0;
      corners_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CAMERA: cam_q <= cfg_data_i;
        REG_TL:     corners_q[CORNER_TL] <= cfg_data_i;
        REG_TR:     corners_q[CORNER_TR] <= cfg_data_i;
        REG_BL:     corners_q[CORNER_BL] <= cfg_data_i;
        REG_BR:     corners_q[CORNER_BR] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  fspc_setup #(.CoordWidth(CoordWidth)) u_setup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cfg_we_i),
    .cam_i     (cam_q),
    .corners_i (corners_q),
    .status_o  (status),
    .unit_o    (units)
  );

  fspc_pipe #(.CoordWidth(CoordWidth)) u_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cam_i    (cam_q),
    .unit_i   (units),
    .hold_i   (cfg_we_i),
    .obj_i    (obj_i),
    .res_o    (res_o)
  );

`ifndef SYNTH
  a_cfg_starts_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> status.busy)
    else $error("configuration write did not start setup");
  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |-> !obj_i.ready)
    else $error("object accepted during a configuration write");
  a_res_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> res_o.valid)
    else $error("waiting result beat dropped");
`endif

endmodule
